/* src/sml_pkg.sv */
// shared constants, codes and types for the sorted multiset list
package sml_pkg;

	localparam int CAPACITY    = 16;
	localparam int VALUE_WIDTH = 32;
	localparam int CNT_W       = $clog2(CAPACITY + 1);
	localparam int CMD_W       = 2;
	localparam int RANK_W      = 4;
	localparam int STATUS_W    = 2;
	localparam int FIELD_W     = 32;
	localparam int COUNT_W     = 5;
	localparam int IN_DATA_W   = ((FIELD_W + RANK_W + 7) / 8) * 8;
	localparam int OUT_DATA_W  = ((COUNT_W + FIELD_W + 7) / 8) * 8;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_DELETE = 2'd1,
		CMD_READ   = 2'd2
	} sml_cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE      = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_RANK      = 2'd3
	} sml_status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_COMPARE,
		S_UPDATE
	} sml_state_t;

	typedef struct packed {
		logic cmp_en;
		logic ins_en;
		logic del_en;
	} sml_ctl_t;

endpackage

/* src/sml_cell.sv */
// one slot of the sorted chain: compare against the key, then shift or load
module sml_cell (
	input  logic                                  clk,
	input  sml_pkg::sml_ctl_t                     ctl,
	input  logic signed [sml_pkg::VALUE_WIDTH-1:0] key,
	input  logic                                  valid,
	input  logic                                  prev_lt,
	input  logic signed [sml_pkg::VALUE_WIDTH-1:0] prev_val,
	input  logic signed [sml_pkg::VALUE_WIDTH-1:0] next_val,
	output logic signed [sml_pkg::VALUE_WIDTH-1:0] val,
	output logic                                  lt,
	output logic                                  hit
);
	import sml_pkg::*;

	logic signed [VALUE_WIDTH-1:0] val_q;
	logic                          lt_q;
	logic                          eq_q;
	logic                          at_pos;

	// this slot is the first one not smaller than the key
	assign at_pos = !lt_q && prev_lt;

	always_ff @(posedge clk) begin
		if (ctl.cmp_en) begin
			lt_q <= valid && (val_q < key);
			eq_q <= valid && (val_q == key);
		end
		if (ctl.ins_en && !lt_q) begin
			val_q <= at_pos ? key : prev_val;
		end else if (ctl.del_en && !lt_q) begin
			val_q <= next_val;
		end
	end

	assign val = val_q;
	assign lt  = lt_q;
	assign hit = at_pos && eq_q;

endmodule

/* src/sorted_multiset_list.sv */
// top level of the sorted multiset list: handshake, control and the chain of cells
// Keeps up to CAPACITY signed values in non-decreasing order in a row of cells, one
// value per cell. Each item passes a compare state, where every cell compares its
// value with the key at once, and an update state, where the cells load the key,
// shift toward the tail (insert) or take their right neighbor's value (delete), so
// the time is the same at any fill. A new item is taken in the same cycle that the
// previous result is written to the output register; the update waits while the
// output side stalls. Reads select the cell at the given rank.
module sorted_multiset_list (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [sml_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // value, rank
	input  logic [sml_pkg::CMD_W-1:0]          s_axis_tuser,  // cmd
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [sml_pkg::OUT_DATA_W-1:0]     m_axis_tdata,  // count, read_value
	output logic [sml_pkg::STATUS_W-1:0]       m_axis_tuser   // status
);
	import sml_pkg::*;

	sml_state_t state_q, state_d;

	logic [CMD_W-1:0]              cmd_s1;
	logic signed [VALUE_WIDTH-1:0] key_s1;
	logic [RANK_W-1:0]             rank_s1;

	logic [CNT_W-1:0]    held_q;
	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [COUNT_W-1:0]  count_q;
	logic [FIELD_W-1:0]  read_value_q;

	logic                          in_fire;
	logic                          upd_fire;
	logic                          out_free;
	logic                          full;
	logic                          found;
	logic [CNT_W-1:0]              rank_ext;
	logic signed [VALUE_WIDTH-1:0] rd_val;
	logic [STATUS_W-1:0]           status_d;
	logic [CNT_W-1:0]              held_d;
	logic [FIELD_W-1:0]            read_value_d;
	logic signed [FIELD_W-1:0]     in_value;
	sml_ctl_t                      ctl;

	logic signed [VALUE_WIDTH-1:0] cell_val [CAPACITY];
	logic                          cell_lt  [CAPACITY];
	logic [CAPACITY-1:0]           cell_hit;

	assign in_value = s_axis_tdata[FIELD_W-1:0];
	assign out_free = !out_valid_q || m_axis_tready;
	assign full     = held_q >= CNT_W'(CAPACITY);
	assign found    = |cell_hit;
	assign rank_ext = CNT_W'(rank_s1);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and handshake
	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		upd_fire      = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					state_d = S_COMPARE;
				end
			end
			S_COMPARE: begin
				state_d = S_UPDATE;
			end
			S_UPDATE: begin
				if (out_free) begin
					upd_fire      = 1'b1;
					s_axis_tready = 1'b1;
					state_d       = s_axis_tvalid ? S_COMPARE : S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign in_fire = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_s1  <= s_axis_tuser;
			key_s1  <= VALUE_WIDTH'(in_value);
			rank_s1 <= s_axis_tdata[FIELD_W +: RANK_W];
		end
	end

	assign ctl.cmp_en = (state_q == S_COMPARE);
	assign ctl.ins_en = upd_fire && (cmd_s1 == CMD_INSERT) && !full;
	assign ctl.del_en = upd_fire && (cmd_s1 == CMD_DELETE) && found;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
		logic                          prev_lt;
		logic signed [VALUE_WIDTH-1:0] prev_val;
		logic signed [VALUE_WIDTH-1:0] next_val;

		if (i == 0) begin : g_head
			assign prev_lt  = 1'b1;
			assign prev_val = key_s1;
		end else begin : g_body
			assign prev_lt  = cell_lt[i-1];
			assign prev_val = cell_val[i-1];
		end
		if (i == CAPACITY - 1) begin : g_tail
			assign next_val = cell_val[i];
		end else begin : g_mid
			assign next_val = cell_val[i+1];
		end

		sml_cell u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.key      (key_s1),
			.valid    (IDX < held_q),
			.prev_lt  (prev_lt),
			.prev_val (prev_val),
			.next_val (next_val),
			.val      (cell_val[i]),
			.lt       (cell_lt[i]),
			.hit      (cell_hit[i])
		);
	end

	// read select by rank
	always_comb begin
		rd_val = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (CNT_W'(i) == rank_ext) begin
				rd_val = cell_val[i];
			end
		end
	end

	// result of the current item
	always_comb begin
		status_d     = ST_DONE;
		held_d       = held_q;
		read_value_d = '0;
		unique case (cmd_s1)
			CMD_INSERT: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					held_d = held_q + CNT_W'(1);
				end
			end
			CMD_DELETE: begin
				if (found) begin
					held_d = held_q - CNT_W'(1);
				end else begin
					status_d = ST_NOT_FOUND;
				end
			end
			CMD_READ: begin
				if (rank_ext < held_q) begin
					read_value_d = FIELD_W'(rd_val);
				end else begin
					status_d = ST_RANK;
				end
			end
			default: begin
				status_d = ST_DONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (upd_fire) begin
				held_q      <= held_d;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd_fire) begin
			status_q     <= status_d;
			count_q      <= COUNT_W'(held_d);
			read_value_q <= read_value_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = status_q;
	assign m_axis_tdata  = OUT_DATA_W'({read_value_q, count_q});

endmodule
